>>> hdl/pcp_pkg.sv
// shared types and constants of the polyline closest point core
package pcp_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_DELTA,
		S_MUL1,
		S_MUL2,
		S_DOT,
		S_DIV,
		S_SCALE,
		S_POS,
		S_SQ,
		S_CMP,
		S_SQRT,
		S_DONE
	} state_t;

	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = 32;
	localparam int FRAC_BITS  = 16;

	typedef struct packed {
		logic                  start;
		logic [SQRT_IN_W-1:0]  value;
	} sqrt_req_t;

	typedef struct packed {
		logic                  done;
		logic [SQRT_OUT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

>>> hdl/pcp_isqrt.sv
// integer square root, two radicand bits per cycle
module pcp_isqrt import pcp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);
	localparam int CW = $clog2(SQRT_OUT_W);

	logic [SQRT_IN_W-1:0]  val_q;
	logic [SQRT_OUT_W+1:0] rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [SQRT_OUT_W+1:0] rem_sh;
	logic [SQRT_OUT_W+1:0] trial;

	assign rem_sh = {rem_q[SQRT_OUT_W-1:0], val_q[SQRT_IN_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SQRT_OUT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q  <= req.value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q <= {val_q[SQRT_IN_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[SQRT_OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[SQRT_OUT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule

>>> hdl/polyline_closest_point_core.sv
// top level: vertex store and closest point search over a polyline
//
// channel   | handshake                | words
// ----------+--------------------------+-----------------------------------------
// command   | start & !busy            | command, coord_x, coord_y, vertex_theta
// result    | done (one cycle)         | distance, closest_x, closest_y, closest_theta
// config    | min_segment_len_sq_we    | min_segment_len_sq
//
// clear and append keep busy low.
// a query keeps busy high from the two vertex reads through the root; a segment is delta, two
// multiply steps, dot, a restoring divide, scale, position, square and compare,
// and the divide is skipped when the fraction is 0 or 1.
// the square root unit runs last; fewer than two vertices skip the walk and the root.
// done rises in the same cycle that busy falls; reset empties the store and clears the register;
// the receiver cannot stall.
module polyline_closest_point_core import pcp_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [31:0] vertex_theta,
	input  logic        min_segment_len_sq_we,
	input  logic [31:0] min_segment_len_sq,
	output logic        done,
	output logic [31:0] distance,
	output logic [31:0] closest_x,
	output logic [31:0] closest_y,
	output logic [31:0] closest_theta
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNTW = AW + 1;
	localparam int DIVW = 4;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	// memory
	logic [95:0]   mem [MAX_VERTICES];
	logic [95:0]   rdata_q;
	logic          ren;
	logic [AW-1:0] raddr;

	state_t state_q, state_d;
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] idx_q;
	logic [31:0] thr_cfg_q;
	logic [47:0] thr_q;
	logic signed [31:0] px_q, py_q;
	logic signed [31:0] ax_q, ay_q, at_q, bx_q, by_q, bt_q;

	logic [32:0] mabx_s1, maby_s1, mdx_s1, mdy_s1, mdth_s1;
	logic        nabx_s1, naby_s1, ndx_s1, ndy_s1, ndth_s1;
	logic [65:0] sqx_s2, sqy_s2, pdx_s3, pdy_s3;
	logic [66:0] len_q;
	logic [67:0] r_q;
	logic [16:0] t_q;
	logic [DIVW-1:0] dcnt_q;
	logic [49:0] smx_s4, smy_s4, smt_s4;
	logic [31:0] cx_s5, cy_s5, ct_s5;
	logic [32:0] mex_s5, mey_s5;
	logic [65:0] exsq_s6, eysq_s6;
	logic        have_q;
	logic [66:0] best_q;
	logic [31:0] best_x_q, best_y_q, bth_q;

	logic        done_q;
	logic [31:0] dist_q, ox_q, oy_q, oth_q;

	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	logic accept;
	logic [66:0] len_w, pos_w, neg_w, dsq_w;
	logic [67:0] r2_w;
	logic [33:0] mx_w, my_w, mt_w;
	logic signed [33:0] cx_w, cy_w, ct_w;
	logic signed [32:0] ex_w, ey_w;
	logic [CNTW-1:0] idx2_w;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign idx2_w = idx_q + CNTW'(2);

	always_ff @(posedge clk) begin
		if (accept && cmd_t'(command) == CMD_APPEND && count_q < CNTW'(MAX_VERTICES))
			mem[count_q[AW-1:0]] <= {coord_x, coord_y, vertex_theta};
		if (ren)
			rdata_q <= mem[raddr];
	end

	always_comb begin
		ren   = 1'b0;
		raddr = '0;
		case (state_q)
			S_IDLE: ren = accept && cmd_t'(command) == CMD_QUERY;
			S_RDA: begin
				ren   = 1'b1;
				raddr = AW'(1);
			end
			S_DELTA: begin
				ren   = 1'b1;
				raddr = idx2_w[AW-1:0];
			end
			default: ren = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd_t'(command) == CMD_QUERY)
					state_d = (count_q < CNTW'(2)) ? S_DONE : S_RDA;
			end
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_DELTA;
			S_DELTA: state_d = S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_DOT;
			S_DOT: begin
				if (len_w > {19'd0, thr_q} && pos_w > neg_w && (pos_w - neg_w) < len_w)
					state_d = S_DIV;
				else
					state_d = S_SCALE;
			end
			S_DIV:   state_d = (dcnt_q == DIVW'(FRAC_BITS - 1)) ? S_SCALE : S_DIV;
			S_SCALE: state_d = S_POS;
			S_POS:   state_d = S_SQ;
			S_SQ:    state_d = S_CMP;
			S_CMP:   state_d = (idx2_w < count_q) ? S_DELTA : S_SQRT;
			S_SQRT:  state_d = sq_rsp.done ? S_IDLE : S_SQRT;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the walk
	always_comb begin
		len_w = 67'(sqx_s2) + 67'(sqy_s2);
		pos_w = '0;
		neg_w = '0;
		if (ndx_s1 != nabx_s1) neg_w = neg_w + 67'(pdx_s3); else pos_w = pos_w + 67'(pdx_s3);
		if (ndy_s1 != naby_s1) neg_w = neg_w + 67'(pdy_s3); else pos_w = pos_w + 67'(pdy_s3);
		r2_w = {r_q[66:0], 1'b0};
		mx_w = 34'((smx_s4 + 50'd32768) >> FRAC_BITS);
		my_w = 34'((smy_s4 + 50'd32768) >> FRAC_BITS);
		mt_w = 34'((smt_s4 + 50'd32768) >> FRAC_BITS);
		cx_w = nabx_s1 ? 34'(ax_q) - $signed(mx_w) : 34'(ax_q) + $signed(mx_w);
		cy_w = naby_s1 ? 34'(ay_q) - $signed(my_w) : 34'(ay_q) + $signed(my_w);
		ct_w = ndth_s1 ? 34'(at_q) - $signed(mt_w) : 34'(at_q) + $signed(mt_w);
		ex_w = 33'(px_q) - 33'($signed(cx_w[31:0]));
		ey_w = 33'(py_q) - 33'($signed(cy_w[31:0]));
		dsq_w = 67'(exsq_s6) + 67'(eysq_s6);
		sq_req.start = (state_q == S_CMP) && !(idx2_w < count_q);
		sq_req.value = (!have_q || dsq_w < best_q) ? dsq_w[63:0] : best_q[63:0];
	end

	pcp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			thr_cfg_q <= '0;
			done_q    <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (min_segment_len_sq_we)
				thr_cfg_q <= min_segment_len_sq;
			if (accept && cmd_t'(command) == CMD_CLEAR)
				count_q <= '0;
			if (accept && cmd_t'(command) == CMD_APPEND && count_q < CNTW'(MAX_VERTICES))
				count_q <= count_q + 1'b1;
			if (state_q == S_IDLE)
				have_q <= 1'b0;
			if (state_q == S_CMP)
				have_q <= 1'b1;
			if (state_q == S_DONE || (state_q == S_SQRT && sq_rsp.done))
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q  <= coord_x;
				py_q  <= coord_y;
				thr_q <= {thr_cfg_q, 16'd0};
				idx_q <= '0;
			end
			S_RDA: begin
				ax_q <= rdata_q[95:64];
				ay_q <= rdata_q[63:32];
				at_q <= rdata_q[31:0];
			end
			S_RDB: begin
				bx_q <= rdata_q[95:64];
				by_q <= rdata_q[63:32];
				bt_q <= rdata_q[31:0];
			end
			S_DELTA: begin
				mabx_s1 <= mag33(33'(bx_q) - 33'(ax_q));
				nabx_s1 <= (33'(bx_q) - 33'(ax_q)) >> 32 != 0;
				maby_s1 <= mag33(33'(by_q) - 33'(ay_q));
				naby_s1 <= (33'(by_q) - 33'(ay_q)) >> 32 != 0;
				mdth_s1 <= mag33(33'(bt_q) - 33'(at_q));
				ndth_s1 <= (33'(bt_q) - 33'(at_q)) >> 32 != 0;
				mdx_s1  <= mag33(33'(px_q) - 33'(ax_q));
				ndx_s1  <= (33'(px_q) - 33'(ax_q)) >> 32 != 0;
				mdy_s1  <= mag33(33'(py_q) - 33'(ay_q));
				ndy_s1  <= (33'(py_q) - 33'(ay_q)) >> 32 != 0;
			end
			S_MUL1: begin
				sqx_s2 <= mabx_s1 * mabx_s1;
				sqy_s2 <= maby_s1 * maby_s1;
			end
			S_MUL2: begin
				pdx_s3 <= mdx_s1 * mabx_s1;
				pdy_s3 <= mdy_s1 * maby_s1;
			end
			S_DOT: begin
				len_q  <= len_w;
				r_q    <= 68'(pos_w - neg_w);
				dcnt_q <= '0;
				if (len_w > {19'd0, thr_q} && pos_w > neg_w && (pos_w - neg_w) >= len_w)
					t_q <= 17'h10000;
				else
					t_q <= '0;
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (r2_w >= {1'b0, len_q}) begin
					r_q <= r2_w - {1'b0, len_q};
					t_q <= {t_q[15:0], 1'b1};
				end else begin
					r_q <= r2_w;
					t_q <= {t_q[15:0], 1'b0};
				end
			end
			S_SCALE: begin
				smx_s4 <= mabx_s1 * t_q;
				smy_s4 <= maby_s1 * t_q;
				smt_s4 <= mdth_s1 * t_q;
			end
			S_POS: begin
				cx_s5  <= cx_w[31:0];
				cy_s5  <= cy_w[31:0];
				ct_s5  <= ct_w[31:0];
				mex_s5 <= mag33(ex_w);
				mey_s5 <= mag33(ey_w);
			end
			S_SQ: begin
				exsq_s6 <= mex_s5 * mex_s5;
				eysq_s6 <= mey_s5 * mey_s5;
			end
			S_CMP: begin
				if (!have_q || dsq_w < best_q) begin
					best_q   <= dsq_w;
					best_x_q <= cx_s5;
					best_y_q <= cy_s5;
					bth_q    <= ct_s5;
				end
				idx_q <= idx_q + 1'b1;
				ax_q  <= bx_q;
				ay_q  <= by_q;
				at_q  <= bt_q;
				bx_q  <= rdata_q[95:64];
				by_q  <= rdata_q[63:32];
				bt_q  <= rdata_q[31:0];
			end
			S_SQRT: begin
				if (sq_rsp.done) begin
					dist_q <= (best_q[66:64] != 3'd0) ? 32'hFFFF_FFFF : sq_rsp.root;
					ox_q   <= best_x_q;
					oy_q   <= best_y_q;
					oth_q  <= bth_q;
				end
			end
			S_DONE: begin
				dist_q <= 32'hFFFF_FFFF;
				ox_q   <= px_q;
				oy_q   <= py_q;
				oth_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	assign done          = done_q;
	assign distance      = dist_q;
	assign closest_x     = ox_q;
	assign closest_y     = oy_q;
	assign closest_theta = oth_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result word without a query");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_QUERY) |=> busy) else $error("query not taken");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_VERTICES)) else $error("vertex count overflow");
	a_sqrt_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		sq_rsp.done |-> state_q == S_SQRT) else $error("root outside query");
endmodule
